>>> design/otsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared widths, limits and types of the Otsu threshold selector.
// ----------------------------------------------------------------------------
package otsu_pkg;

	localparam int HIST_BINS       = 256;
	localparam int MAX_PIXELS_LOG2 = 22;
	localparam int BIN_W           = $clog2(HIST_BINS);
	// pixel and bin counts, able to hold the limit itself
	localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
	// weighted sums t * count
	localparam int SUM_W           = CNT_W + BIN_W;
	// f * bs, b * fs and their difference
	localparam int PROD_W          = CNT_W + SUM_W;
	localparam int NUM_W           = 2 * PROD_W;
	localparam int DEN_W           = 2 * CNT_W;
	// serial multiplier operands and product
	localparam int MA_W            = NUM_W;
	localparam int MB_W            = (PROD_W > DEN_W) ? PROD_W : DEN_W;
	localparam int MP_W            = MA_W + MB_W;

	localparam logic [CNT_W-1:0] PIXEL_LIMIT = CNT_W'(1) << MAX_PIXELS_LOG2;
	localparam logic [BIN_W-1:0] NO_SPLIT_THRESHOLD = BIN_W'(128);

	typedef struct packed {
		logic            start;
		logic [MA_W-1:0] a;
		logic [MB_W-1:0] b;
	} mul_req_t;

endpackage

>>> design/otsu_threshold_select_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_threshold_select_core
// Histogram of one frame of gray pixels, then an exact Otsu threshold sweep.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       to core    in_valid / in_ready    pixel, is_last
// out      from core  out_valid / out_ready  threshold, uniform, overflow
//
// Pixels are taken one per cycle in ST_IDLE; the histogram bin is read, incremented and
// written back through the RAM, with one-deep forwarding for repeated values.
// A last pixel starts the sweep: a drain state, a pass over all bins for the frame
// sum, then per threshold at most RD, H, P, Q, DEN and the serial products NUM, LHS, RHS.
// A clearing pass over all 256 RAM bins follows reset and every frame; no pixel
// is taken during it or during the sweep. A waiting result does not stop
// pixels of the next frame from being taken.
// ----------------------------------------------------------------------------
module otsu_threshold_select_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    pixel,
	input  logic                          is_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    threshold,
	output logic                          uniform,
	output logic                          overflow
);

	localparam int BW = otsu_pkg::BIN_W;
	localparam int CW = otsu_pkg::CNT_W;
	localparam int SW = otsu_pkg::SUM_W;
	localparam int PW = otsu_pkg::PROD_W;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_DRAIN, ST_TOT, ST_RD, ST_H, ST_P, ST_Q,
		ST_DEN, ST_NUM, ST_LHS, ST_RHS, ST_FIN
	} state_t;

	state_t state_q;

	// RAM ports
	logic          we;
	logic [BW-1:0] waddr;
	logic [CW-1:0] wdata;
	logic [BW-1:0] raddr;
	logic [CW-1:0] rdata;

	// accumulate pipeline
	logic          valid_s1;
	logic [BW-1:0] addr_s1;
	logic          wr_valid_s2;
	logic [BW-1:0] wr_addr_s2;
	logic [CW-1:0] wr_data_s2;
	logic [CW-1:0] inc_val;

	// frame and sweep registers
	logic [CW-1:0]            count_q;
	logic                     ovf_q;
	logic [BW:0]              idx_q;
	logic [BW-1:0]            t_q;
	logic [SW-1:0]            total_q;
	logic [CW-1:0]            b_q;
	logic [SW-1:0]            bs_q;
	logic [PW-1:0]            p_q;
	logic [PW-1:0]            d_q;
	logic [otsu_pkg::DEN_W-1:0] den_q;
	logic [otsu_pkg::NUM_W-1:0] num_q;
	logic [otsu_pkg::MP_W-1:0]  lhs_q;
	logic                     have_q;
	logic [BW-1:0]            best_q;
	logic [otsu_pkg::NUM_W-1:0] best_num_q;
	logic [otsu_pkg::MB_W-1:0]  best_den_q;

	// output register
	logic          out_valid_q;
	logic [BW-1:0] thr_q;
	logic          uni_q;
	logic          ovf_out_q;

	// sweep datapath
	logic [BW-1:0]              tot_bin;
	logic [CW-1:0]              b_new;
	logic [CW-1:0]              f_cur;
	logic [PW-1:0]              q_val;
	logic                       last_t;
	otsu_pkg::mul_req_t         mreq;
	logic                       mdone;
	logic [otsu_pkg::MP_W-1:0]  mprod;

	otsu_hist_ram #(
		.DEPTH(otsu_pkg::HIST_BINS),
		.WIDTH(CW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	otsu_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.done    (mdone),
		.product (mprod)
	);

	assign in_ready = (state_q == ST_IDLE);

	// forward the bin written in the previous cycle
	assign inc_val = ((wr_valid_s2 && (wr_addr_s2 == addr_s1)) ? wr_data_s2 : rdata) + CW'(1);

	// RAM write: clearing pass or histogram increment
	always_comb begin
		if (state_q == ST_CLR) begin
			we    = 1'b1;
			waddr = idx_q[BW-1:0];
			wdata = '0;
		end else begin
			we    = valid_s1;
			waddr = addr_s1;
			wdata = inc_val;
		end
	end

	// RAM read address
	always_comb begin
		case (state_q)
			ST_IDLE: raddr = pixel;
			ST_TOT:  raddr = idx_q[BW-1:0];
			default: raddr = t_q;
		endcase
	end

	// bin whose count arrives on the read data during the frame sum
	assign tot_bin = idx_q[BW-1:0] - BW'(1);

	assign b_new  = b_q + rdata;
	assign f_cur  = count_q - b_q;
	assign q_val  = PW'(b_q * (total_q - bs_q));
	assign last_t = (t_q == BW'(otsu_pkg::HIST_BINS - 1));

	// serial multiplier requests
	always_comb begin
		mreq = '0;
		case (state_q)
			ST_DEN: begin
				mreq.start = 1'b1;
				mreq.a     = otsu_pkg::MA_W'(d_q);
				mreq.b     = otsu_pkg::MB_W'(d_q);
			end
			ST_NUM: begin
				mreq.start = mdone;
				mreq.a     = otsu_pkg::MA_W'(mprod);
				mreq.b     = best_den_q;
			end
			ST_LHS: begin
				mreq.start = mdone;
				mreq.a     = best_num_q;
				mreq.b     = otsu_pkg::MB_W'(den_q);
			end
			default: mreq = '0;
		endcase
	end

	// increment pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			wr_valid_s2 <= 1'b0;
		end else begin
			valid_s1    <= in_valid && in_ready && (count_q != otsu_pkg::PIXEL_LIMIT);
			wr_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= pixel;
		wr_addr_s2 <= addr_s1;
		wr_data_s2 <= inc_val;
	end

	// control: frame counting, sweep sequence and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			idx_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			t_q         <= '0;
			have_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					idx_q <= idx_q + (BW+1)'(1);
					if (idx_q == (BW+1)'(otsu_pkg::HIST_BINS - 1)) begin
						idx_q   <= '0;
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (count_q != otsu_pkg::PIXEL_LIMIT) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (is_last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					idx_q   <= '0;
					total_q <= '0;
					state_q <= ST_TOT;
				end
				ST_TOT: begin
					idx_q <= idx_q + (BW+1)'(1);
					if (idx_q != '0) begin
						total_q <= total_q + SW'(tot_bin * rdata);
					end
					if (idx_q == (BW+1)'(otsu_pkg::HIST_BINS)) begin
						idx_q      <= '0;
						t_q        <= '0;
						b_q        <= '0;
						bs_q       <= '0;
						have_q     <= 1'b0;
						best_q     <= otsu_pkg::NO_SPLIT_THRESHOLD;
						best_num_q <= '0;
						best_den_q <= otsu_pkg::MB_W'(1);
						state_q    <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_H;
				end
				ST_H: begin
					b_q  <= b_new;
					bs_q <= bs_q + SW'(t_q * rdata);
					if (b_new == '0) begin
						t_q     <= t_q + BW'(1);
						state_q <= last_t ? ST_FIN : ST_RD;
					end else if (count_q == b_new) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_P;
					end
				end
				ST_P: begin
					p_q     <= PW'(f_cur * bs_q);
					state_q <= ST_Q;
				end
				ST_Q: begin
					d_q     <= (p_q >= q_val) ? (p_q - q_val) : (q_val - p_q);
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					den_q   <= otsu_pkg::DEN_W'(b_q * f_cur);
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					if (mdone) begin
						num_q   <= otsu_pkg::NUM_W'(mprod);
						state_q <= ST_LHS;
					end
				end
				ST_LHS: begin
					if (mdone) begin
						lhs_q   <= mprod;
						state_q <= ST_RHS;
					end
				end
				ST_RHS: begin
					if (mdone) begin
						if (!have_q || (lhs_q > mprod)) begin
							have_q     <= 1'b1;
							best_q     <= t_q;
							best_num_q <= num_q;
							best_den_q <= otsu_pkg::MB_W'(den_q);
						end
						t_q     <= t_q + BW'(1);
						state_q <= last_t ? ST_FIN : ST_RD;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						thr_q       <= best_q;
						uni_q       <= !have_q;
						ovf_out_q   <= ovf_q;
						idx_q       <= '0;
						state_q     <= ST_CLR;
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign threshold = thr_q;
	assign uniform   = uni_q;
	assign overflow  = ovf_out_q;

endmodule

>>> design/otsu_hist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_hist_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module otsu_hist_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 23
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/otsu_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_serial_mul
// Shift-and-add multiplier, one bit of the b operand per cycle.
// ----------------------------------------------------------------------------
module otsu_serial_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  otsu_pkg::mul_req_t            req,
	output logic                          done,
	output logic [otsu_pkg::MP_W-1:0]     product
);

	localparam int CW = $clog2(otsu_pkg::MB_W + 1);

	logic [otsu_pkg::MP_W-1:0] a_q;
	logic [otsu_pkg::MB_W-1:0] b_q;
	logic [otsu_pkg::MP_W-1:0] acc_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;

	// load on start, then add and shift until b is used up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(otsu_pkg::MB_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= otsu_pkg::MP_W'(req.a);
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

>>> design/otsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_checker
// Port-level checks of the Otsu threshold selector, bound to the top level.
// ----------------------------------------------------------------------------
module otsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       is_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] threshold,
	input logic       uniform
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(threshold) && $stable(uniform))
		else $error("result changed while stalled");

	// no split always reports the middle threshold
	a_uniform_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && uniform |-> threshold == 8'd128)
		else $error("uniform result with wrong threshold");

	// results appear only while pixel intake is closed
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared during pixel intake");

	// a pixel that is not last starts no sweep
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !is_last |=> in_ready)
		else $error("intake closed after a pixel that was not last");

endmodule

bind otsu_threshold_select_core otsu_checker u_otsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.is_last   (is_last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.threshold (threshold),
	.uniform   (uniform)
);
